FILE: rtl/ldr_pkg.sv
// Package for the lens distortion remap address generator.
// Holds the configuration record, register index codes and fixed widths.
// No dependencies; every other file but the two channel interfaces imports it.
package ldr_pkg;

   localparam int CSR_AW    = 5;
   localparam int DIV_STEPS = 14;

   localparam logic signed [27:0] NORM_MAX = 28'sh7FFFFFF;
   localparam logic signed [27:0] NORM_MIN = 28'sh8000000;

   typedef struct packed {
      logic        [19:0] focal_x;
      logic        [19:0] focal_y;
      logic        [19:0] center_x;
      logic        [19:0] center_y;
      logic signed [23:0] radial_k1;
      logic signed [23:0] radial_k2;
      logic signed [23:0] tangential_p1;
      logic signed [23:0] tangential_p2;
   } ldr_cfg_type;

   typedef enum logic [2:0] {
      REG_FOCAL_X = 3'd0,
      REG_FOCAL_Y = 3'd1,
      REG_CENTER_X = 3'd2,
      REG_CENTER_Y = 3'd3,
      REG_RADIAL_K1 = 3'd4,
      REG_RADIAL_K2 = 3'd5,
      REG_TANG_P1 = 3'd6,
      REG_TANG_P2 = 3'd7
   } ldr_reg_type;

endpackage

FILE: rtl/ldr_req_if.sv
// Request channel carrying one output pixel coordinate per word.
// Standalone interface; no dependencies.
interface ldr_req_if;
   logic        valid;
   logic        ready;
   logic [10:0] out_col;
   logic [9:0]  out_row;

   modport source (output valid, output out_col, output out_row, input ready);
   modport sink (input valid, input out_col, input out_row, output ready);
endinterface

FILE: rtl/ldr_rsp_if.sv
// Response channel carrying one source coordinate and frame flag per word.
// Standalone interface; no dependencies.
interface ldr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [12:0] source_col;
   logic signed [12:0] source_row;
   logic               inside_frame;

   modport source (output valid, output source_col, output source_row,
                   output inside_frame, input ready);
   modport sink (input valid, input source_col, input source_row,
                 input inside_frame, output ready);
endinterface

FILE: rtl/ldr_csr.sv
// Configuration register bank with an APB-style write and read port.
// Depends on ldr_pkg for the configuration record and register codes.
module ldr_csr
   import ldr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output ldr_cfg_type       cfg
);

   ldr_cfg_type cfg_ff;
   ldr_reg_type idx;
   logic        wr_en;

   assign idx        = ldr_reg_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x       <= 20'd110021;
         cfg_ff.focal_y       <= 20'd110033;
         cfg_ff.center_x      <= 20'd163269;
         cfg_ff.center_y      <= 20'd122104;
         cfg_ff.radial_k1     <= '0;
         cfg_ff.radial_k2     <= '0;
         cfg_ff.tangential_p1 <= '0;
         cfg_ff.tangential_p2 <= '0;
      end else if (wr_en) begin
         unique case (idx)
            REG_FOCAL_X: cfg_ff.focal_x <= csr_pwdata[19:0];
            REG_FOCAL_Y: cfg_ff.focal_y <= csr_pwdata[19:0];
            REG_CENTER_X: cfg_ff.center_x <= csr_pwdata[19:0];
            REG_CENTER_Y: cfg_ff.center_y <= csr_pwdata[19:0];
            REG_RADIAL_K1: cfg_ff.radial_k1 <= $signed(csr_pwdata[23:0]);
            REG_RADIAL_K2: cfg_ff.radial_k2 <= $signed(csr_pwdata[23:0]);
            REG_TANG_P1: cfg_ff.tangential_p1 <= $signed(csr_pwdata[23:0]);
            REG_TANG_P2: cfg_ff.tangential_p2 <= $signed(csr_pwdata[23:0]);
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FOCAL_X: csr_prdata = {12'h000, cfg_ff.focal_x};
         REG_FOCAL_Y: csr_prdata = {12'h000, cfg_ff.focal_y};
         REG_CENTER_X: csr_prdata = {12'h000, cfg_ff.center_x};
         REG_CENTER_Y: csr_prdata = {12'h000, cfg_ff.center_y};
         REG_RADIAL_K1: csr_prdata = {{8{cfg_ff.radial_k1[23]}}, cfg_ff.radial_k1};
         REG_RADIAL_K2: csr_prdata = {{8{cfg_ff.radial_k2[23]}}, cfg_ff.radial_k2};
         REG_TANG_P1: csr_prdata = {{8{cfg_ff.tangential_p1[23]}}, cfg_ff.tangential_p1};
         REG_TANG_P2: csr_prdata = {{8{cfg_ff.tangential_p2[23]}}, cfg_ff.tangential_p2};
      endcase
   end

endmodule

FILE: rtl/ldr_norm.sv
// Normalizer: offset from the principal point divided by the focal length.
// Pipelined restoring divider, two quotient bits per stage. Uses ldr_pkg.
module ldr_norm
   import ldr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               ce,
   input  logic               in_valid,
   input  logic [10:0]        pix_x,
   input  logic [10:0]        pix_y,
   input  ldr_cfg_type        cfg,
   output logic               out_valid,
   output logic signed [27:0] xn,
   output logic signed [27:0] yn
);

   localparam int NS = DIV_STEPS;

   logic [NS+1:0]      vld_ff;
   logic [47:0]        rem_ff [2][0:NS-1];
   logic [47:0]        rem_in [2][1:NS-1];
   logic [27:0]        quo_ff [2][1:NS];
   logic [27:0]        quo_in [2][1:NS];
   logic [NS:0]        neg_ff [2];
   logic [NS:0]        ovf_ff [2];
   logic [NS:0]        zero_ff [2];
   logic signed [27:0] nrm_ff [2];
   logic signed [27:0] nrm_in [2];
   logic [47:0]        rem0_in [2];
   logic [1:0]         neg0_in;
   logic [1:0]         ovf0_in;
   logic [1:0]         zero0_in;

   // Stage 0: signed offset in Q.8, its magnitude and the overflow test.
   // The quotient reaches 2^28 exactly when the magnitude is at least 16 * focal.
   always_comb begin
      logic [10:0]        pix;
      logic [19:0]        ctr;
      logic [19:0]        foc;
      logic signed [20:0] dif;
      logic [19:0]        mag;
      for (int ln = 0; ln < 2; ln++) begin
         pix = (ln == 0) ? pix_x : pix_y;
         ctr = (ln == 0) ? cfg.center_x : cfg.center_y;
         foc = (ln == 0) ? cfg.focal_x : cfg.focal_y;
         dif = $signed({2'b00, pix, 8'h00}) - $signed({1'b0, ctr});
         mag = dif[20] ? 20'(-dif) : dif[19:0];
         rem0_in[ln]  = {4'h0, mag, 24'h000000};
         neg0_in[ln]  = dif[20];
         zero0_in[ln] = (dif == '0);
         ovf0_in[ln]  = (dif != '0) && ({4'h0, mag} >= {foc, 4'h0});
      end
   end

   // Divider stages: stage s settles quotient bits 2*(NS-s)+1 and 2*(NS-s).
   always_comb begin
      logic [19:0] foc;
      logic [47:0] dvh;
      logic [47:0] dvl;
      logic [47:0] rh;
      logic [47:0] rl;
      logic [27:0] qp;
      logic        qh;
      logic        ql;
      for (int ln = 0; ln < 2; ln++) begin
         foc = (ln == 0) ? cfg.focal_x : cfg.focal_y;
         for (int s = 1; s <= NS; s++) begin
            dvh = {28'h0, foc} << (2 * (NS - s) + 1);
            dvl = {28'h0, foc} << (2 * (NS - s));
            qh  = rem_ff[ln][s-1] >= dvh;
            rh  = qh ? rem_ff[ln][s-1] - dvh : rem_ff[ln][s-1];
            ql  = rh >= dvl;
            rl  = ql ? rh - dvl : rh;
            qp  = (s == 1) ? 28'h0 : quo_ff[ln][s-1];
            quo_in[ln][s] = qp | (28'(qh) << (2 * (NS - s) + 1))
                               | (28'(ql) << (2 * (NS - s)));
            if (s < NS) begin
               rem_in[ln][s] = rl;
            end
         end
      end
   end

   // Sign and saturation of the truncated quotient.
   always_comb begin
      logic [27:0] q;
      for (int ln = 0; ln < 2; ln++) begin
         q = quo_ff[ln][NS];
         priority if (zero_ff[ln][NS]) begin
            nrm_in[ln] = '0;
         end else if (ovf_ff[ln][NS]) begin
            nrm_in[ln] = neg_ff[ln][NS] ? NORM_MIN : NORM_MAX;
         end else if (!neg_ff[ln][NS]) begin
            nrm_in[ln] = q[27] ? NORM_MAX : $signed(q);
         end else begin
            nrm_in[ln] = q[27] ? NORM_MIN : -$signed(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[NS:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int ln = 0; ln < 2; ln++) begin
            rem_ff[ln][0] <= rem0_in[ln];
            for (int s = 1; s < NS; s++) begin
               rem_ff[ln][s] <= rem_in[ln][s];
            end
            for (int s = 1; s <= NS; s++) begin
               quo_ff[ln][s] <= quo_in[ln][s];
            end
            neg_ff[ln]  <= {neg_ff[ln][NS-1:0], neg0_in[ln]};
            ovf_ff[ln]  <= {ovf_ff[ln][NS-1:0], ovf0_in[ln]};
            zero_ff[ln] <= {zero_ff[ln][NS-1:0], zero0_in[ln]};
            nrm_ff[ln]  <= nrm_in[ln];
         end
      end
   end

   assign out_valid = vld_ff[NS+1];
   assign xn        = nrm_ff[0];
   assign yn        = nrm_ff[1];

`ifndef ASSERT_OFF
   // A zero offset must leave the normalizer as zero, even with a zero focal length.
   a_zero_offset: assert property (@(posedge clock) disable iff (reset)
      ce && vld_ff[NS] && zero_ff[0][NS] |=> nrm_ff[0] == '0)
      else $error("zero column offset did not normalize to zero");
   a_zero_offset_y: assert property (@(posedge clock) disable iff (reset)
      ce && vld_ff[NS] && zero_ff[1][NS] |=> nrm_ff[1] == '0)
      else $error("zero row offset did not normalize to zero");
`endif

endmodule

FILE: rtl/ldr_distort.sv
// Brown-Conrady distortion of the normalized coordinate, seven stages.
// One register after every multiplier bank. Uses ldr_pkg.
module ldr_distort
   import ldr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               ce,
   input  logic               in_valid,
   input  logic signed [27:0] xn,
   input  logic signed [27:0] yn,
   input  ldr_cfg_type        cfg,
   output logic               out_valid,
   output logic signed [38:0] xd,
   output logic signed [38:0] yd
);

   logic [6:0] vld_ff;

   // Stage 1: squares and cross product.
   logic signed [55:0] p_xx, p_yy, p_xy;
   logic signed [31:0] xx_s1_ff, yy_s1_ff, xy_s1_ff;
   logic signed [27:0] xn_s1_ff, yn_s1_ff;
   // Stage 2: radius squared and tangential sums.
   logic signed [32:0] r2_s2_in;
   logic signed [32:0] r2_s2_ff;
   logic signed [33:0] tx_s2_ff, ty_s2_ff;
   logic signed [31:0] xy_s2_ff;
   logic signed [27:0] xn_s2_ff, yn_s2_ff;
   // Stage 3: r^4 and coefficient products.
   logic signed [65:0] p_r4;
   logic signed [56:0] p_k1r2;
   logic signed [55:0] p_p1xy, p_p2xy;
   logic signed [57:0] p_p2tx, p_p1ty;
   logic signed [39:0] r4_s3_ff;
   logic signed [35:0] k1r2_s3_ff;
   logic signed [34:0] p1xy_s3_ff, p2xy_s3_ff;
   logic signed [36:0] p2tx_s3_ff, p1ty_s3_ff;
   logic signed [27:0] xn_s3_ff, yn_s3_ff;
   // Stage 4: k2 * r^4.
   logic signed [63:0] p_k2r4;
   logic signed [42:0] k2r4_s4_ff;
   logic signed [35:0] k1r2_s4_ff;
   logic signed [34:0] p1xy_s4_ff, p2xy_s4_ff;
   logic signed [36:0] p2tx_s4_ff, p1ty_s4_ff;
   logic signed [27:0] xn_s4_ff, yn_s4_ff;
   // Stage 5: radial factor, saturated to Q8.24.
   logic signed [43:0] rsum;
   logic signed [31:0] radial_s5_in;
   logic signed [31:0] radial_s5_ff;
   logic signed [34:0] p1xy_s5_ff, p2xy_s5_ff;
   logic signed [36:0] p2tx_s5_ff, p1ty_s5_ff;
   logic signed [27:0] xn_s5_ff, yn_s5_ff;
   // Stage 6: radial scaling.
   logic signed [59:0] p_rx, p_ry;
   logic signed [35:0] rx_s6_ff, ry_s6_ff;
   logic signed [34:0] p1xy_s6_ff, p2xy_s6_ff;
   logic signed [36:0] p2tx_s6_ff, p1ty_s6_ff;
   // Stage 7: distorted coordinate.
   logic signed [38:0] xd_s7_ff, yd_s7_ff;

   assign p_xx = xn * xn;
   assign p_yy = yn * yn;
   assign p_xy = xn * yn;

   assign r2_s2_in = 33'(xx_s1_ff) + 33'(yy_s1_ff);

   assign p_r4   = r2_s2_ff * r2_s2_ff;
   assign p_k1r2 = cfg.radial_k1 * r2_s2_ff;
   assign p_p1xy = cfg.tangential_p1 * xy_s2_ff;
   assign p_p2xy = cfg.tangential_p2 * xy_s2_ff;
   assign p_p2tx = cfg.tangential_p2 * tx_s2_ff;
   assign p_p1ty = cfg.tangential_p1 * ty_s2_ff;

   assign p_k2r4 = cfg.radial_k2 * r4_s3_ff;

   assign rsum = 44'sd16777216 + 44'(k1r2_s4_ff) + 44'(k2r4_s4_ff);

   always_comb begin
      priority if (rsum > 44'sd2147483647) begin
         radial_s5_in = 32'sh7FFFFFFF;
      end else if (rsum < -44'sd2147483648) begin
         radial_s5_in = 32'sh80000000;
      end else begin
         radial_s5_in = 32'(rsum);
      end
   end

   assign p_rx = radial_s5_ff * xn_s5_ff;
   assign p_ry = radial_s5_ff * yn_s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         xx_s1_ff <= 32'(p_xx >>> 24);
         yy_s1_ff <= 32'(p_yy >>> 24);
         xy_s1_ff <= 32'(p_xy >>> 24);
         xn_s1_ff <= xn;
         yn_s1_ff <= yn;

         r2_s2_ff <= r2_s2_in;
         tx_s2_ff <= 34'(r2_s2_in) + (34'(xx_s1_ff) <<< 1);
         ty_s2_ff <= 34'(r2_s2_in) + (34'(yy_s1_ff) <<< 1);
         xy_s2_ff <= xy_s1_ff;
         xn_s2_ff <= xn_s1_ff;
         yn_s2_ff <= yn_s1_ff;

         r4_s3_ff   <= 40'(p_r4 >>> 24);
         k1r2_s3_ff <= 36'(p_k1r2 >>> 20);
         p1xy_s3_ff <= 35'(p_p1xy >>> 20);
         p2xy_s3_ff <= 35'(p_p2xy >>> 20);
         p2tx_s3_ff <= 37'(p_p2tx >>> 20);
         p1ty_s3_ff <= 37'(p_p1ty >>> 20);
         xn_s3_ff   <= xn_s2_ff;
         yn_s3_ff   <= yn_s2_ff;

         k2r4_s4_ff <= 43'(p_k2r4 >>> 20);
         k1r2_s4_ff <= k1r2_s3_ff;
         p1xy_s4_ff <= p1xy_s3_ff;
         p2xy_s4_ff <= p2xy_s3_ff;
         p2tx_s4_ff <= p2tx_s3_ff;
         p1ty_s4_ff <= p1ty_s3_ff;
         xn_s4_ff   <= xn_s3_ff;
         yn_s4_ff   <= yn_s3_ff;

         radial_s5_ff <= radial_s5_in;
         p1xy_s5_ff   <= p1xy_s4_ff;
         p2xy_s5_ff   <= p2xy_s4_ff;
         p2tx_s5_ff   <= p2tx_s4_ff;
         p1ty_s5_ff   <= p1ty_s4_ff;
         xn_s5_ff     <= xn_s4_ff;
         yn_s5_ff     <= yn_s4_ff;

         rx_s6_ff   <= 36'(p_rx >>> 24);
         ry_s6_ff   <= 36'(p_ry >>> 24);
         p1xy_s6_ff <= p1xy_s5_ff;
         p2xy_s6_ff <= p2xy_s5_ff;
         p2tx_s6_ff <= p2tx_s5_ff;
         p1ty_s6_ff <= p1ty_s5_ff;

         xd_s7_ff <= 39'(rx_s6_ff) + (39'(p1xy_s6_ff) <<< 1) + 39'(p2tx_s6_ff);
         yd_s7_ff <= 39'(ry_s6_ff) + 39'(p1ty_s6_ff) + (39'(p2xy_s6_ff) <<< 1);
      end
   end

   assign out_valid = vld_ff[6];
   assign xd        = xd_s7_ff;
   assign yd        = yd_s7_ff;

endmodule

FILE: rtl/ldr_denorm.sv
// Denormalization, rounding (add one half, truncate toward zero), saturation and the frame test.
// Its last stage is the response output register. Uses ldr_pkg.
module ldr_denorm
   import ldr_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 1280,
   parameter int IMAGE_HEIGHT = 960
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               ce,
   input  logic               in_valid,
   input  logic signed [38:0] xd,
   input  logic signed [38:0] yd,
   input  ldr_cfg_type        cfg,
   output logic               out_valid,
   output logic signed [12:0] source_col,
   output logic signed [12:0] source_row,
   output logic               inside_frame
);

   localparam logic signed [27:0] W_LIM = 28'(IMAGE_WIDTH);
   localparam logic signed [27:0] H_LIM = 28'(IMAGE_HEIGHT);

   logic [1:0]         vld_ff;
   logic signed [59:0] p_fx, p_fy;
   logic signed [33:0] fx_ff, fy_ff;
   logic signed [27:0] tc, tr;
   logic signed [12:0] col_in, row_in;
   logic signed [12:0] col_ff, row_ff;
   logic               inside_in, inside_ff;

   assign p_fx = $signed({1'b0, cfg.focal_x}) * xd;
   assign p_fy = $signed({1'b0, cfg.focal_y}) * yd;

   function automatic logic signed [27:0] round_pix(input logic signed [33:0] f,
                                                    input logic [19:0] ctr);
      logic signed [34:0] w;
      logic [34:0]        wa;
      logic [26:0]        tq;
      w  = 35'(f) + $signed({15'h0000, ctr}) + 35'sd128;
      wa = w[34] ? 35'(-w) : w;
      tq = wa[34:8];
      return w[34] ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
   endfunction

   function automatic logic signed [12:0] sat13(input logic signed [27:0] t);
      logic signed [12:0] r;
      priority if (t > 28'sd4095) begin
         r = 13'sd4095;
      end else if (t < -28'sd4096) begin
         r = -13'sd4096;
      end else begin
         r = t[12:0];
      end
      return r;
   endfunction

   assign tc        = round_pix(fx_ff, cfg.center_x);
   assign tr        = round_pix(fy_ff, cfg.center_y);
   assign col_in    = sat13(tc);
   assign row_in    = sat13(tr);
   assign inside_in = (tc >= 0) && (tr >= 0) && (tc < W_LIM) && (tr < H_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         fx_ff     <= 34'(p_fx >>> 24);
         fy_ff     <= 34'(p_fy >>> 24);
         col_ff    <= col_in;
         row_ff    <= row_in;
         inside_ff <= inside_in;
      end
   end

   assign out_valid    = vld_ff[1];
   assign source_col   = col_ff;
   assign source_row   = row_ff;
   assign inside_frame = inside_ff;

`ifndef ASSERT_OFF
   a_inside_nonneg: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] && inside_ff |-> !col_ff[12] && !row_ff[12])
      else $error("inside_frame set for a negative source coordinate");
`endif

endmodule

FILE: rtl/lens_distortion_remap_address_top.sv
// Lens distortion remap address generator, top level.
// Stages: normalize and divide, distortion, denormalize; throughput one word
// per cycle while no response word waits to be taken.
// The whole pipeline holds while a response word waits to be taken.
// Synchronous active-high reset clears the valid bits and loads the default
// calibration registers; data registers are not reset.
module lens_distortion_remap_address_top
   import ldr_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 1280,
   parameter int IMAGE_HEIGHT = 960
) (
   input  logic              clock,
   input  logic              reset,
   ldr_req_if.sink           req_chan,
   ldr_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   ldr_cfg_type        cfg;
   logic               ce;
   logic               nrm_valid, dst_valid;
   logic signed [27:0] xn, yn;
   logic signed [38:0] xd, yd;

   // The pipeline moves unless the output word is stalled.
   assign ce             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = ce;

   ldr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ldr_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (req_chan.valid),
      .pix_x     (req_chan.out_col),
      .pix_y     ({1'b0, req_chan.out_row}),
      .cfg       (cfg),
      .out_valid (nrm_valid),
      .xn        (xn),
      .yn        (yn)
   );

   ldr_distort u_distort (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (nrm_valid),
      .xn        (xn),
      .yn        (yn),
      .cfg       (cfg),
      .out_valid (dst_valid),
      .xd        (xd),
      .yd        (yd)
   );

   ldr_denorm #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_denorm (
      .clock        (clock),
      .reset        (reset),
      .ce           (ce),
      .in_valid     (dst_valid),
      .xd           (xd),
      .yd           (yd),
      .cfg          (cfg),
      .out_valid    (rsp_chan.valid),
      .source_col   (rsp_chan.source_col),
      .source_row   (rsp_chan.source_row),
      .inside_frame (rsp_chan.inside_frame)
   );

`ifndef ASSERT_OFF
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request word accepted while the output word is stalled");
   a_stall_holds_norm: assert property (@(posedge clock) disable iff (reset)
      !ce |=> $stable(xn) && $stable(yn) && $stable(nrm_valid))
      else $error("normalizer output moved during a stall");
   a_stall_holds_dist: assert property (@(posedge clock) disable iff (reset)
      !ce |=> $stable(xd) && $stable(yd) && $stable(dst_valid))
      else $error("distortion output moved during a stall");
`endif

endmodule

FILE: test/lens_distortion_remap_address_top_test.sv
// Self-checking testbench for lens_distortion_remap_address_top.
// Drives pixel coordinates under random backpressure, predicts each source word
// in fixed point and compares it; depends on ldr_pkg, the two channel interfaces and the top.
module lens_distortion_remap_address_top_test;
   import ldr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IMG_W = 1280;
   localparam int IMG_H = 960;
   localparam int LATENCY = 25;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      int col;
      int row;
   } pixel_type;

   typedef struct {
      logic signed [12:0] source_col;
      logic signed [12:0] source_row;
      logic               inside_frame;
   } remap_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   ldr_req_if req_if ();
   ldr_rsp_if rsp_if ();

   lens_distortion_remap_address_top i_dut (
      .clock(clock), .reset(reset), .req_chan(req_if), .rsp_chan(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ldr_cfg_type calib;
   pixel_type pending_pixels[$];
   remap_type expected_remaps[$];
   int errors = 0;
   int cycles = 0;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;
   bit long_hold_request = 1'b0;

   function automatic longint norm_coord(int pix, longint center, longint focal);
      longint d;
      d = longint'(pix) * 256 - center;
      if (focal == 0) return d > 0 ? 134217727 : (d < 0 ? -134217728 : 0);
      d = (d * 16777216) / focal;
      if (d > 134217727) return 134217727;
      if (d < -134217728) return -134217728;
      return d;
   endfunction

   function automatic longint denorm_round(longint d, longint focal, longint center);
      longint v;
      v = ((focal * d) >>> 24) + center;
      return (v + 128) / 256;
   endfunction

   function automatic logic signed [12:0] clip13(longint v);
      if (v > 4095) return 13'sd4095;
      if (v < -4096) return -13'sd4096;
      return v[12:0];
   endfunction

   function automatic remap_type predict_remap(pixel_type p);
      longint fx, fy, cx, cy, k1, k2, p1, p2;
      longint xn, yn, xx, yy, xy, r2, r4, radial, xd, yd, sc, sr;
      remap_type r;
      fx = calib.focal_x; fy = calib.focal_y;
      cx = calib.center_x; cy = calib.center_y;
      k1 = $signed(calib.radial_k1); k2 = $signed(calib.radial_k2);
      p1 = $signed(calib.tangential_p1); p2 = $signed(calib.tangential_p2);
      xn = norm_coord(p.col, cx, fx);
      yn = norm_coord(p.row, cy, fy);
      xx = (xn * xn) >>> 24;
      yy = (yn * yn) >>> 24;
      xy = (xn * yn) >>> 24;
      r2 = xx + yy;
      r4 = (r2 * r2) >>> 24;
      radial = 16777216 + ((k1 * r2) >>> 20) + ((k2 * r4) >>> 20);
      if (radial > 64'sd2147483647) radial = 64'sd2147483647;
      if (radial < -64'sd2147483648) radial = -64'sd2147483648;
      xd = ((radial * xn) >>> 24) + 2 * ((p1 * xy) >>> 20) + ((p2 * (r2 + 2 * xx)) >>> 20);
      yd = ((radial * yn) >>> 24) + ((p1 * (r2 + 2 * yy)) >>> 20) + 2 * ((p2 * xy) >>> 20);
      sc = denorm_round(xd, fx, cx);
      sr = denorm_round(yd, fy, cy);
      r.source_col = clip13(sc);
      r.source_row = clip13(sr);
      r.inside_frame = (sc >= 0 && sr >= 0 && sc < IMG_W && sr < IMG_H);
      return r;
   endfunction

   // Sender: after each word it waits a drawn number of cycles before the next.
   int send_gap = 0;
   always @(posedge clock) begin
      pixel_type p;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.out_col <= '0;
         req_if.out_row <= '0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            p = pending_pixels.pop_front();
            req_if.out_col <= p.col[10:0];
            req_if.out_row <= p.row[9:0];
            req_if.valid <= 1'b1;
            send_gap = sender_steady ? 0 : $urandom_range(0, 14);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver and checker. The long hold lets the pipeline fill and stall its input.
   int rsp_stall = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      pixel_type p;
      remap_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            p.col = req_if.out_col;
            p.row = req_if.out_row;
            expected_remaps.push_back(predict_remap(p));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_remaps.size() == 0) begin
               errors++;
               $display("%0t: unexpected word col %0d row %0d inside %0d", $time,
                        rsp_if.source_col, rsp_if.source_row, rsp_if.inside_frame);
            end else begin
               e = expected_remaps.pop_front();
               if (rsp_if.source_col !== e.source_col) begin
                  errors++;
                  $display("%0t: source_col expected %0d actual %0d", $time,
                           e.source_col, rsp_if.source_col);
               end
               if (rsp_if.source_row !== e.source_row) begin
                  errors++;
                  $display("%0t: source_row expected %0d actual %0d", $time,
                           e.source_row, rsp_if.source_row);
               end
               if (rsp_if.inside_frame !== e.inside_frame) begin
                  errors++;
                  $display("%0t: inside_frame expected %0d actual %0d", $time,
                           e.inside_frame, rsp_if.inside_frame);
               end
            end
            rsp_stall = receiver_steady ? 0 : $urandom_range(0, 14);
         end
         if (long_hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("lens_distortion_remap_address_top regression: fail");
         $finish;
      end
   end

   task automatic csr_write(ldr_reg_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_FOCAL_X:   calib.focal_x = value[19:0];
         REG_FOCAL_Y:   calib.focal_y = value[19:0];
         REG_CENTER_X:  calib.center_x = value[19:0];
         REG_CENTER_Y:  calib.center_y = value[19:0];
         REG_RADIAL_K1: calib.radial_k1 = value[23:0];
         REG_RADIAL_K2: calib.radial_k2 = value[23:0];
         REG_TANG_P1:   calib.tangential_p1 = value[23:0];
         REG_TANG_P2:   calib.tangential_p2 = value[23:0];
         default: ;
      endcase
   endtask

   task automatic set_calib(int fx, int fy, int cx, int cy, int k1, int k2, int p1, int p2);
      csr_write(REG_FOCAL_X, fx);
      csr_write(REG_FOCAL_Y, fy);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_RADIAL_K1, k1);
      csr_write(REG_RADIAL_K2, k2);
      csr_write(REG_TANG_P1, p1);
      csr_write(REG_TANG_P2, p2);
   endtask

   // The queues are looked at on the falling edge, when the clocked processes have settled.
   task automatic drain();
      while (pending_pixels.size() > 0 || req_if.valid || expected_remaps.size() > 0)
         @(negedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic queue_pixel(int col, int row);
      pixel_type p;
      p.col = col;
      p.row = row;
      pending_pixels.push_back(p);
   endtask

   task automatic queue_random(int count);
      repeat (count) begin
         if ($urandom_range(0, 7) == 0)
            queue_pixel($urandom_range(0, 2047), $urandom_range(0, 1023));
         else
            queue_pixel($urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1));
      end
   endtask

   initial begin
      calib.focal_x = 20'd110021;
      calib.focal_y = 20'd110033;
      calib.center_x = 20'd163269;
      calib.center_y = 20'd122104;
      calib.radial_k1 = '0;
      calib.radial_k2 = '0;
      calib.tangential_p1 = '0;
      calib.tangential_p2 = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed corners and center under the reset calibration.
      queue_pixel(0, 0);
      queue_pixel(1279, 959);
      queue_pixel(2047, 1023);
      queue_pixel(637, 476);
      queue_pixel(638, 477);
      queue_pixel(0, 1023);
      queue_pixel(2047, 0);
      drain();

      // Typical wide-angle lens, with the far-off coordinates as well.
      set_calib(110021, 110033, 163269, 122104, -198117, 28563, 825, -4133);
      queue_pixel(0, 0);
      queue_pixel(1279, 959);
      queue_pixel(2047, 1023);
      queue_pixel(637, 476);
      drain();

      // Zero focal length on one axis, full-scale on the other, extreme terms.
      set_calib(0, 1048575, 1048575, 0, 8388607, -8388608, -8388608, 8388607);
      queue_pixel(0, 0);
      queue_pixel(2047, 1023);
      queue_pixel(1279, 959);
      queue_pixel(4095 / 2, 0);
      drain();
      set_calib(1048575, 0, 0, 1048575, -8388608, 8388607, 8388607, -8388608);
      queue_pixel(0, 0);
      queue_pixel(2047, 1023);
      queue_pixel(0, 959);
      queue_pixel(1279, 0);
      drain();
      // An offset of exactly zero against a zero focal length.
      set_calib(1, 0, 256, 256 * 100, 0, 0, 0, 0);
      queue_pixel(1, 100);
      queue_pixel(0, 99);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         int pick;
         pick = $urandom_range(0, 3);
         if (pick == 0)
            set_calib($urandom_range(0, 1048575), $urandom_range(0, 1048575),
                      $urandom_range(0, 1048575), $urandom_range(0, 1048575),
                      $urandom, $urandom, $urandom, $urandom);
         else
            set_calib($urandom_range(40000, 400000), $urandom_range(40000, 400000),
                      $urandom_range(100000, 230000), $urandom_range(80000, 170000),
                      $signed($urandom_range(0, 1 << 19)) - (1 << 18),
                      $signed($urandom_range(0, 1 << 17)) - (1 << 16),
                      $signed($urandom_range(0, 1 << 14)) - (1 << 13),
                      $signed($urandom_range(0, 1 << 14)) - (1 << 13));
         sender_steady = (ph % 3 == 1);
         receiver_steady = (ph % 4 == 2);
         if (ph == 3) begin
            sender_steady = 1'b1;
            long_hold_request = 1'b1;
         end
         queue_random(150);
         // The sender pauses here until every word of the phase is back.
         drain();
      end

      if (expected_remaps.size() > 0) errors++;
      if (errors == 0) begin
         $display("lens_distortion_remap_address_top regression: pass");
      end else begin
         $display("lens_distortion_remap_address_top regression: fail");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/ldr_pkg.sv
rtl/ldr_req_if.sv
rtl/ldr_rsp_if.sv
rtl/ldr_csr.sv
rtl/ldr_norm.sv
rtl/ldr_distort.sv
rtl/ldr_denorm.sv
rtl/lens_distortion_remap_address_top.sv
test/lens_distortion_remap_address_top_test.sv
